/* sv/dlrcm_pkg.sv */
// ----------------------------------------------------------------------------
// dlrcm_pkg - shared types and constants of the dual-line ring chunk manager
// Operation and status codes, bus widths, and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dlrcm_pkg;

	// Stream and register port widths
	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 5;
	localparam int M_TDATA_W  = 168;
	localparam int M_TUSER_W  = 2;
	localparam int APB_ADDR_W = 3;

	// Remainder unit: dividend width and iteration counter width
	localparam int DVD_W     = 17;
	localparam int MOD_CNT_W = 5;

	// Reset value of the ring size register
	localparam logic [15:0] BUFFER_SIZE_RST = 16'd32768;

	// Register select taken from paddr[2]
	localparam logic REG_BUFFER_SIZE = 1'b0;
	localparam logic REG_MARGIN_SIZE = 1'b1;

	// Line numbers
	localparam logic [1:0] LINE_FREE = 2'd0;
	localparam logic [1:0] LINE_DATA = 2'd1;

	typedef enum logic [2:0] {
		MODE_GET   = 3'd0,
		MODE_UNGET = 3'd1,
		MODE_PUT   = 3'd2,
		MODE_QUERY = 3'd3,
		MODE_RESET = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_LINE = 2'd1,
		STAT_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WAIT1,
		ST_START2,
		ST_WAIT2,
		ST_FINISH
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic mod_start;
		logic mod_second;
		logic cap_first;
		logic cap_second;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_mod;
		logic need_second;
		logic mod_done;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* sv/dlrcm_mod.sv */
// ----------------------------------------------------------------------------
// dlrcm_mod - iterative remainder unit
// Reduces an unsigned dividend modulo a non-zero divisor. A dividend below
// twice the divisor takes the short path; otherwise one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrcm_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dlrcm_pkg::DVD_W-1:0] dividend,
	input  wire logic [dlrcm_pkg::DVD_W-1:0] divisor,
	output logic                             done,
	output logic [dlrcm_pkg::DVD_W-1:0]      remainder
);
	import dlrcm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     rem_q;
	logic [DVD_W-1:0]     dvd_q;

	logic                 quick;
	logic [DVD_W-1:0]     quick_rem;
	logic [DVD_W:0]       trial;
	logic [DVD_W-1:0]     step_rem;

	// Short path: at most one subtraction needed
	assign quick     = {1'b0, dividend} < {divisor, 1'b0};
	assign quick_rem = (dividend >= divisor) ? dividend - divisor : dividend;

	// Restoring step: shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		if (trial >= {1'b0, divisor}) begin
			step_rem = DVD_W'(trial - {1'b0, divisor});
		end else begin
			step_rem = trial[DVD_W-1:0];
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (quick) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= MOD_CNT_W'(DVD_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MOD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= quick ? quick_rem : '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= step_rem;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* sv/dlrcm_dp.sv */
// ----------------------------------------------------------------------------
// dlrcm_dp - datapath of the dual-line ring chunk manager
// Holds the request, the two lines' offsets, counts and totals, the shared
// remainder unit and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrcm_dp #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dlrcm_pkg::ctl_cmd_t             cmd,
	output dlrcm_pkg::dp_stat_t                  stat,
	input  wire logic [dlrcm_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [dlrcm_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic [15:0]                     buffer_size,
	input  wire logic [15:0]                     margin_size,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [dlrcm_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [dlrcm_pkg::M_TUSER_W-1:0]      m_tuser
);
	import dlrcm_pkg::*;

	localparam int OFS_W = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
	localparam int CNT_W = OFFSET_BITS;
	localparam int CMP_W = (OFFSET_BITS > 18) ? OFFSET_BITS : 18;

	// Request registers
	logic [2:0]  mode_q;
	logic [1:0]  line_q;
	logic [15:0] len_q;
	logic [15:0] pos_q;

	// Line state
	logic [OFS_W-1:0] free_offset_q;
	logic [OFS_W-1:0] data_offset_q;
	logic [CNT_W-1:0] free_count_q;
	logic [CNT_W-1:0] data_count_q;
	logic [31:0]      taken_q [2];
	logic [31:0]      put_q [2];

	// Captured remainders
	logic [DVD_W-1:0] r1_q;
	logic [DVD_W-1:0] r2_q;

	// Result word
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic             valid_line;
	logic             sel;
	logic [OFS_W-1:0] cur_off;
	logic [CNT_W-1:0] cur_cnt;
	logic [15:0]      off16;
	logic [16:0]      m17;
	logic [18:0]      room19;
	logic [17:0]      room18;
	logic [17:0]      lim18;
	logic [CMP_W-1:0] cnt_cmp;
	logic [CMP_W-1:0] lim_cmp;
	logic [CMP_W-1:0] grant_w;
	logic [15:0]      g16;
	logic [16:0]      get_dvd;
	logic [17:0]      x18;
	logic [17:0]      x_abs;
	logic             x_neg;
	logic             match;
	logic [DVD_W-1:0] mod_dvd;
	logic             mod_done;
	logic [DVD_W-1:0] mod_rem;

	// Next-state and result values of the step
	logic [OFS_W-1:0] nxt_off;
	logic [CNT_W-1:0] nxt_cnt;
	logic [31:0]      nxt_taken;
	logic [31:0]      nxt_put;
	logic             line_wr;
	logic             lines_rst;
	status_t          res_status;
	logic [15:0]      res_chunk_len;
	logic [15:0]      res_chunk_off;
	logic             res_fsr;
	logic [15:0]      res_mirror;
	logic [15:0]      res_wsrc;
	logic [15:0]      res_wlen;
	logic [CNT_W-1:0] rep_cnt;
	logic [31:0]      rep_taken;
	logic [31:0]      rep_put;
	logic [15:0]      res_line_count;
	logic [31:0]      res_taken;
	logic [31:0]      res_put;
	logic [15:0]      ml16;
	logic [16:0]      end17;
	logic [16:0]      wl17;
	logic [15:0]      wl16;
	logic [16:0]      wsrc17;

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= s_tuser[2:0];
			line_q <= s_tuser[4:3];
			len_q  <= s_tdata[15:0];
			pos_q  <= s_tdata[31:16];
		end
	end

	// Select the addressed line
	assign valid_line = !line_q[1];
	assign sel        = line_q[0];
	assign cur_off    = sel ? data_offset_q : free_offset_q;
	assign cur_cnt    = sel ? data_count_q : free_count_q;
	assign off16      = 16'(cur_off);

	// Ring modulus, a zero size standing for a full 64 KiB ring
	assign m17 = (buffer_size == 16'd0) ? 17'h10000 : {1'b0, buffer_size};

	// Grant: smallest of line count, room to ring end plus margin, request
	always_comb begin
		room19  = 19'(margin_size) + 19'(m17) - 19'(off16);
		room18  = room19[18] ? 18'd0 : room19[17:0];
		lim18   = (18'(len_q) < room18) ? 18'(len_q) : room18;
		cnt_cmp = CMP_W'(cur_cnt);
		lim_cmp = CMP_W'(lim18);
		grant_w = (cnt_cmp < lim_cmp) ? cnt_cmp : lim_cmp;
	end
	assign g16     = grant_w[15:0];
	assign get_dvd = 17'(off16) + 17'(g16);

	// Unget: expected position before reduction, as sign and magnitude
	always_comb begin
		x18   = 18'(off16) + 18'(m17) - 18'(len_q);
		x_neg = x18[17];
		x_abs = x_neg ? 18'd0 - x18 : x18;
	end

	// A negative expected position matches only when it reduces to zero
	assign match = x_neg ? (r1_q == '0) && (r2_q == '0) : (r1_q == r2_q);

	// Feed the remainder unit
	always_comb begin
		if (cmd.mod_second) begin
			mod_dvd = 17'(pos_q);
		end else if (mode_q == MODE_UNGET) begin
			mod_dvd = x_abs[DVD_W-1:0];
		end else begin
			mod_dvd = get_dvd;
		end
	end

	dlrcm_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (mod_dvd),
		.divisor   (m17),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Hold the remainders between reductions
	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			r1_q <= mod_rem;
		end
		if (cmd.cap_second) begin
			r2_q <= mod_rem;
		end
	end

	// Work out the step outcome
	always_comb begin
		nxt_off       = cur_off;
		nxt_cnt       = cur_cnt;
		nxt_taken     = taken_q[sel];
		nxt_put       = put_q[sel];
		line_wr       = 1'b0;
		lines_rst     = 1'b0;
		res_status    = STAT_OK;
		res_chunk_len = '0;
		res_chunk_off = '0;
		res_fsr       = 1'b0;
		res_mirror    = '0;
		res_wsrc      = '0;
		res_wlen      = '0;
		ml16          = margin_size - pos_q;
		end17         = 17'(pos_q) + 17'(len_q);
		wl17          = end17 - m17;
		wl16          = (17'(len_q) < wl17) ? len_q : wl17[15:0];
		wsrc17        = end17 - 17'(wl16);
		unique case (mode_q)
			MODE_GET: begin
				if (!valid_line) begin
					res_status = STAT_BAD_LINE;
				end else begin
					res_chunk_len = g16;
					res_chunk_off = off16;
					nxt_off       = r1_q[OFS_W-1:0];
					nxt_cnt       = cur_cnt - CNT_W'(g16);
					nxt_taken     = taken_q[sel] + 32'(g16);
					line_wr       = 1'b1;
				end
			end
			MODE_UNGET: begin
				if (len_q != 16'd0) begin
					if (!valid_line) begin
						res_status = STAT_BAD_LINE;
					end else begin
						if (match) begin
							nxt_off = r1_q[OFS_W-1:0];
							nxt_cnt = cur_cnt + CNT_W'(len_q);
						end else begin
							res_status = STAT_MISMATCH;
						end
						nxt_taken = taken_q[sel] - 32'(len_q);
						line_wr   = 1'b1;
					end
				end
			end
			MODE_PUT: begin
				if (len_q != 16'd0) begin
					if (!valid_line) begin
						res_status = STAT_BAD_LINE;
					end else begin
						nxt_cnt = cur_cnt + CNT_W'(len_q);
						nxt_put = put_q[sel] + 32'(len_q);
						line_wr = 1'b1;
						// Data line: report margin mirror and wrap copies
						if (sel) begin
							if (pos_q < margin_size) begin
								res_mirror = (len_q < ml16) ? len_q : ml16;
							end
							if (end17 > m17) begin
								res_wsrc = wsrc17[15:0];
								res_wlen = wl16;
							end
						end
					end
				end
			end
			MODE_QUERY: begin
				if (!valid_line) begin
					res_status = STAT_BAD_LINE;
					res_fsr    = (len_q == 16'd0);
				end else begin
					res_chunk_len = g16;
					res_fsr       = (g16 == len_q);
				end
			end
			MODE_RESET: begin
				lines_rst = 1'b1;
			end
			default: begin
				if (!valid_line) begin
					res_status = STAT_BAD_LINE;
				end
			end
		endcase
	end

	// Report the addressed line after the step
	always_comb begin
		if (lines_rst) begin
			rep_cnt   = sel ? '0 : CNT_W'(buffer_size);
			rep_taken = '0;
			rep_put   = '0;
		end else begin
			rep_cnt   = nxt_cnt;
			rep_taken = nxt_taken;
			rep_put   = nxt_put;
		end
		res_line_count = valid_line ? 16'(rep_cnt) : 16'd0;
		res_taken      = valid_line ? rep_taken : 32'd0;
		res_put        = valid_line ? rep_put : 32'd0;
	end

	// Commit line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_offset_q <= '0;
			data_offset_q <= '0;
			free_count_q  <= CNT_W'(BUFFER_SIZE_RST);
			data_count_q  <= '0;
			taken_q[0]    <= '0;
			taken_q[1]    <= '0;
			put_q[0]      <= '0;
			put_q[1]      <= '0;
		end else if (cmd.commit) begin
			if (lines_rst) begin
				free_offset_q <= '0;
				data_offset_q <= '0;
				free_count_q  <= CNT_W'(buffer_size);
				data_count_q  <= '0;
				taken_q[0]    <= '0;
				taken_q[1]    <= '0;
				put_q[0]      <= '0;
				put_q[1]      <= '0;
			end else if (line_wr) begin
				if (sel) begin
					data_offset_q <= nxt_off;
					data_count_q  <= nxt_cnt;
				end else begin
					free_offset_q <= nxt_off;
					free_count_q  <= nxt_cnt;
				end
				taken_q[sel] <= nxt_taken;
				put_q[sel]   <= nxt_put;
			end
		end
	end

	// Result word: hold until taken, load on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {7'd0, res_put, res_taken, res_wlen, res_wsrc, res_mirror,
				res_line_count, res_fsr, res_chunk_off, res_chunk_len};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Status towards the controller
	assign stat.need_mod    = valid_line && ((mode_q == MODE_GET) ||
		((mode_q == MODE_UNGET) && (len_q != 16'd0)));
	assign stat.need_second = (mode_q == MODE_UNGET);
	assign stat.mod_done    = mod_done;
	assign stat.out_free    = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

/* sv/dlrcm_ctrl.sv */
// ----------------------------------------------------------------------------
// dlrcm_ctrl - controller of the dual-line ring chunk manager
// Takes one request word, sequences the remainder reductions it needs and
// commits the step once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dlrcm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire dlrcm_pkg::dp_stat_t stat,
	output dlrcm_pkg::ctl_cmd_t      cmd
);
	import dlrcm_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.need_mod) begin
					cmd.mod_start = 1'b1;
					state_nxt     = ST_WAIT1;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_WAIT1: begin
				if (stat.mod_done) begin
					cmd.cap_first = 1'b1;
					state_nxt     = stat.need_second ? ST_START2 : ST_FINISH;
				end
			end
			ST_START2: begin
				cmd.mod_start  = 1'b1;
				cmd.mod_second = 1'b1;
				state_nxt      = ST_WAIT2;
			end
			ST_WAIT2: begin
				if (stat.mod_done) begin
					cmd.cap_second = 1'b1;
					state_nxt      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/dual_line_ring_chunk_manager.sv */
// ----------------------------------------------------------------------------
// dual_line_ring_chunk_manager - ring buffer free/data chunk manager
// Tracks free space and filled data of a ring with mirrored margin as two
// lines, grants and returns chunks, and issues copy descriptors for puts.
//
//   Channel   Direction  Word contents
//   s_*       in         tuser: mode, line; tdata: req_length, position
//   m_*       out        tuser: status; tdata: result fields
//   APB       in/out     buffer_size at 0x0, margin_size at 0x4
//
// A word that needs no reduction (put, query, reset, unused modes, an empty
// unget or an invalid line) goes straight to commit; a get on a valid line
// needs one reduction modulo the ring size, a non-empty unget on a valid line
// two, each on the short path when one subtraction suffices, else one quotient
// bit per cycle in the shared remainder unit. A reset request reinitialises
// both lines. A result word is held in the output register while the sink
// stalls; the next request is taken once the current result is loaded there.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_line_ring_chunk_manager #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// tdata: req_length[15:0], position[31:16]
	input  wire logic [dlrcm_pkg::S_TDATA_W-1:0]  s_tdata,
	// tuser: mode[2:0], line[4:3]
	input  wire logic [dlrcm_pkg::S_TUSER_W-1:0]  s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// tdata: chunk_length[15:0], chunk_offset[31:16], full_size_ready[32],
	// line_count[48:33], mirror_len[64:49], wrap_src[80:65],
	// wrap_len[96:81], taken_total[128:97], put_total[160:129], zeros above
	output logic [dlrcm_pkg::M_TDATA_W-1:0]       m_tdata,
	// tuser: status[1:0]
	output logic [dlrcm_pkg::M_TUSER_W-1:0]       m_tuser,
	// register port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [dlrcm_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import dlrcm_pkg::*;

	logic        cfg_wr;
	logic [15:0] buffer_size_q;
	logic [15:0] margin_size_q;
	ctl_cmd_t    cmd;
	dp_stat_t    stat;

	// Register port: ready is held high, so an access never waits
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUFFER_SIZE_RST;
			margin_size_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MARGIN_SIZE) begin
				margin_size_q <= pwdata[15:0];
			end else begin
				buffer_size_q <= pwdata[15:0];
			end
		end
	end

	// Read back
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? 32'(buffer_size_q) : 32'(margin_size_q);

	dlrcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dlrcm_dp #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.buffer_size (buffer_size_q),
		.margin_size (margin_size_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

`ifndef SYNTHESIS
	// A result word appears only from a commit
	a_word_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("result word raised without commit");

	// A commit never overwrites a result that the sink has not taken
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("commit over pending result word");

	// One request at a time: acceptance closes the input until committed
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while one is in flight");

	// The remainder unit is never restarted while a reduction is awaited
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |=> !cmd.mod_start)
		else $error("remainder unit started twice in a row");
`endif

endmodule

`default_nettype wire

/* tb/sv/dual_line_ring_chunk_manager_test.sv */
// ----------------------------------------------------------------------------
// dual_line_ring_chunk_manager_test - stream-level test of the chunk manager
// Drives request words on the slave stream and register writes on the APB
// port, models the free and data lines alongside the block, and compares
// every result word field by field in order. Both streams idle at random,
// the sink holds off once for a long stretch, and the run steps through
// several ring and margin settings, the extremes among them.
// ----------------------------------------------------------------------------

module dual_line_ring_chunk_manager_test;
	import dlrcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;
	localparam logic [APB_ADDR_W-1:0] ADDR_RING   = {REG_BUFFER_SIZE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_MARGIN = {REG_MARGIN_SIZE, 2'b00};

	// One result word, split into its fields
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] chunk_length;
		logic [15:0] chunk_offset;
		logic        full_ready;
		logic [15:0] line_count;
		logic [15:0] mirror_len;
		logic [15:0] wrap_src;
		logic [15:0] wrap_len;
		logic [31:0] taken_total;
		logic [31:0] put_total;
	} chunk_result_t;

	// Line model of the ring and the queue of results still awaited
	class chunk_line_book;
		logic [15:0] ring_size;
		logic [15:0] margin_size;
		logic [15:0] line_off[2];
		logic [15:0] line_cnt[2];
		logic [31:0] taken_sum[2];
		logic [31:0] put_sum[2];
		logic [15:0] grant_off[2];
		logic [15:0] grant_len[2];
		chunk_result_t awaited[$];
		int mismatches;
		int results_seen;

		function longint ring_mod();
			longint m;
			m = ring_size;
			return (ring_size != 0) ? m : 65536;
		endfunction

		function void clear_lines();
			line_off[0] = '0;
			line_off[1] = '0;
			line_cnt[0] = ring_size;
			line_cnt[1] = '0;
			taken_sum[0] = '0;
			taken_sum[1] = '0;
			put_sum[0] = '0;
			put_sum[1] = '0;
		endfunction

		function void power_on();
			ring_size = BUFFER_SIZE_RST;
			margin_size = '0;
			grant_off[0] = '0;
			grant_off[1] = '0;
			grant_len[0] = '0;
			grant_len[1] = '0;
			clear_lines();
		endfunction

		function void set_reg(logic sel, logic [15:0] value);
			if (sel == REG_BUFFER_SIZE)
				ring_size = value;
			else
				margin_size = value;
		endfunction

		// Smallest of line count, room to ring end plus margin, and request
		function logic [15:0] grant_of(longint cnt, longint off, longint req);
			longint room;
			longint a;
			room = longint'(margin_size) + ring_mod() - off;
			a = cnt;
			if (room < 0)
				room = 0;
			if (room < a)
				a = room;
			if (req < a)
				a = req;
			return a[15:0];
		endfunction

		// Advance the line model by one accepted request and queue its result
		function void apply_request(logic [2:0] mode, logic [1:0] ln,
				logic [15:0] len, logic [15:0] pos);
			chunk_result_t r;
			longint m, e, act, fin, wl, off_l, len_l, pos_l;
			logic [15:0] g, ml;
			bit ok;
			int li;
			ok = (ln < 2);
			li = ln[0];
			r = '0;
			m = ring_mod();
			off_l = line_off[li];
			len_l = len;
			pos_l = pos;
			case (mode)
				MODE_GET: begin
					if (!ok) begin
						r.status = STAT_BAD_LINE;
					end else begin
						g = grant_of(line_cnt[li], off_l, len_l);
						r.chunk_length = g;
						r.chunk_offset = line_off[li];
						grant_off[li] = line_off[li];
						grant_len[li] = g;
						line_off[li] = 16'((off_l + longint'(g)) % m);
						line_cnt[li] = line_cnt[li] - g;
						taken_sum[li] = taken_sum[li] + {16'b0, g};
					end
				end
				MODE_UNGET: begin
					if (len == 0) begin
						// zero-length unget leaves everything alone
					end else if (!ok) begin
						r.status = STAT_BAD_LINE;
					end else begin
						e = (off_l + m - len_l) % m;
						act = pos_l % m;
						if (e == act) begin
							line_off[li] = e[15:0];
							line_cnt[li] = line_cnt[li] + len;
						end else begin
							r.status = STAT_MISMATCH;
						end
						taken_sum[li] = taken_sum[li] - {16'b0, len};
					end
				end
				MODE_PUT: begin
					if (len == 0) begin
						// zero-length put leaves everything alone
					end else if (!ok) begin
						r.status = STAT_BAD_LINE;
					end else begin
						line_cnt[li] = line_cnt[li] + len;
						put_sum[li] = put_sum[li] + {16'b0, len};
						if (ln == LINE_DATA) begin
							fin = pos_l + len_l;
							if (pos < margin_size) begin
								ml = margin_size - pos;
								if (len < ml)
									ml = len;
								r.mirror_len = ml;
							end
							if (fin > m) begin
								wl = fin - m;
								if (len_l < wl)
									wl = len_l;
								r.wrap_src = 16'(fin - wl);
								r.wrap_len = 16'(wl);
							end
						end
					end
				end
				MODE_QUERY: begin
					if (!ok) begin
						r.status = STAT_BAD_LINE;
						r.full_ready = (len == 0);
					end else begin
						g = grant_of(line_cnt[li], off_l, len_l);
						r.chunk_length = g;
						r.full_ready = (g == len);
					end
				end
				MODE_RESET: begin
					clear_lines();
				end
				default: begin
					if (!ok)
						r.status = STAT_BAD_LINE;
				end
			endcase
			if (ok) begin
				r.line_count = line_cnt[li];
				r.taken_total = taken_sum[li];
				r.put_total = put_sum[li];
			end
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected 0x%0h, got 0x%0h",
						results_seen, name, want, got);
			end
		endfunction

		// Split a result word and compare it with the oldest awaited result
		function void check_result(logic [M_TDATA_W-1:0] td, logic [M_TUSER_W-1:0] tu);
			chunk_result_t got, want;
			got.status = tu;
			got.chunk_length = td[15:0];
			got.chunk_offset = td[31:16];
			got.full_ready = td[32];
			got.line_count = td[48:33];
			got.mirror_len = td[64:49];
			got.wrap_src = td[80:65];
			got.wrap_len = td[96:81];
			got.taken_total = td[128:97];
			got.put_total = td[160:129];
			results_seen++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: word arrived with nothing outstanding",
						results_seen);
				return;
			end
			want = awaited.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("chunk_length", want.chunk_length, got.chunk_length);
			compare_field("chunk_offset", want.chunk_offset, got.chunk_offset);
			compare_field("full_size_ready", want.full_ready, got.full_ready);
			compare_field("line_count", want.line_count, got.line_count);
			compare_field("mirror_len", want.mirror_len, got.mirror_len);
			compare_field("wrap_src", want.wrap_src, got.wrap_src);
			compare_field("wrap_len", want.wrap_len, got.wrap_len);
			compare_field("taken_total", want.taken_total, got.taken_total);
			compare_field("put_total", want.put_total, got.put_total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	chunk_line_book book;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int cycles = 0;
	int words_sent = 0;
	int settings_used = 0;
	int mode_hits[8];

	dual_line_ring_chunk_manager u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Abort a run that has stopped making progress
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("dual_line_ring_chunk_manager_test failed");
			$finish;
		end
	end

	// Check every result word taken by the sink
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tdata, m_tuser);
	end

	// Sink: random short stalls, plus one long hold-off on request
	initial begin : sink_ready
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one request word and hold it until the block takes it
	task automatic send_word(logic [2:0] mode, logic [1:0] ln,
			logic [15:0] len, logic [15:0] pos);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {ln, mode};
		s_tdata <= {pos, len};
		do
			@(posedge clk);
		while (!s_tready);
		book.apply_request(mode, ln, len, pos);
		words_sent++;
		mode_hits[mode]++;
	endtask

	// Wait until every awaited result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Setup and access phases, then the register port goes idle
	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		book.set_reg(addr[2], value);
		@(posedge clk);
	endtask

	task automatic set_ring(logic [15:0] ring, logic [15:0] margin);
		apb_write(ADDR_RING, ring);
		apb_write(ADDR_MARGIN, margin);
		settings_used++;
	endtask

	// Request size: mostly small, sometimes up to the ring, rarely anything or a corner value
	function automatic logic [15:0] pick_len();
		int m;
		m = int'(book.ring_mod());
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom_range(0, 64));
			5, 6, 7:       return 16'($urandom_range(0, m));
			8:             return 16'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'd0;
					1:       return 16'd1;
					2:       return 16'd32768;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// Mostly producer/consumer traffic built on the current line state
	task automatic random_word();
		int pick;
		int li;
		longint m, e, off_l;
		logic [15:0] len;
		logic [15:0] pos;
		m = book.ring_mod();
		li = $urandom_range(0, 1);
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			send_word(MODE_GET, 2'(li), pick_len(), 16'($urandom));
		end else if (pick < 48) begin
			// hand the other line's last grant over to this line
			len = book.grant_len[1 - li];
			if (len == 0)
				len = 16'($urandom_range(1, 64));
			send_word(MODE_PUT, 2'(li), len, book.grant_off[1 - li]);
		end else if (pick < 60) begin
			// roll back to where the chunk should have started
			len = 16'($urandom_range(1, (book.grant_len[li] == 0) ? 8 : book.grant_len[li]));
			off_l = book.line_off[li];
			e = (off_l + m - longint'(len)) % m;
			pos = (e < 0) ? 16'd0 : e[15:0];
			send_word(MODE_UNGET, 2'(li), len, pos);
		end else if (pick < 68) begin
			send_word(MODE_UNGET, 2'(li), pick_len(), 16'($urandom));
		end else if (pick < 78) begin
			send_word(MODE_QUERY, 2'(li), pick_len(), 16'($urandom));
		end else if (pick < 82) begin
			send_word(MODE_RESET, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
		end else begin
			send_word(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
				16'($urandom), 16'($urandom));
		end
	endtask

	task automatic run_phase(logic [15:0] ring, logic [15:0] margin, int n);
		set_ring(ring, margin);
		send_word(MODE_RESET, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
		repeat (n) random_word();
		drain();
	endtask

	initial begin : stimulus
		logic [15:0] rnd_ring;
		book = new;
		book.power_on();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset settings
		send_word(MODE_QUERY, LINE_FREE, 16'd32768, 16'd0);
		send_word(MODE_QUERY, LINE_FREE, 16'd0, 16'd0);
		send_word(MODE_GET, LINE_FREE, 16'd100, 16'd0);
		send_word(MODE_PUT, LINE_DATA, 16'd100, 16'd0);
		send_word(MODE_GET, LINE_DATA, 16'hFFFF, 16'd0);
		send_word(MODE_UNGET, LINE_DATA, 16'd100, 16'd0);
		send_word(MODE_UNGET, LINE_DATA, 16'd10, 16'd5);
		send_word(MODE_UNGET, 2'd3, 16'd0, 16'hFFFF);
		send_word(MODE_PUT, 2'd2, 16'd0, 16'd0);
		send_word(MODE_PUT, 2'd3, 16'd5, 16'd0);
		send_word(MODE_GET, 2'd2, 16'd1, 16'd0);
		send_word(MODE_QUERY, 2'd3, 16'd0, 16'd0);
		send_word(MODE_QUERY, 2'd2, 16'd7, 16'd0);
		send_word(3'd5, LINE_FREE, 16'hFFFF, 16'hFFFF);
		send_word(3'd6, 2'd3, 16'd1, 16'd1);
		send_word(3'd7, LINE_DATA, 16'd0, 16'd0);
		send_word(MODE_PUT, LINE_DATA, 16'd20, 16'd32760);
		send_word(MODE_PUT, LINE_FREE, 16'hFFFF, 16'hFFFF);
		send_word(MODE_RESET, 2'd3, 16'hFFFF, 16'hFFFF);
		send_word(MODE_GET, LINE_FREE, 16'd20000, 16'd0);
		drain();

		// Shrink the ring under a far offset, then margin and wrap copies
		set_ring(16'd16, 16'd4);
		send_word(MODE_GET, LINE_FREE, 16'd5, 16'd0);
		send_word(MODE_QUERY, LINE_FREE, 16'd5, 16'd0);
		send_word(MODE_RESET, LINE_FREE, 16'd0, 16'd0);
		send_word(MODE_PUT, LINE_DATA, 16'd30, 16'd2);
		send_word(MODE_PUT, LINE_DATA, 16'd3, 16'd10);
		send_word(MODE_UNGET, LINE_FREE, 16'd40, 16'd0);
		send_word(MODE_UNGET, LINE_FREE, 16'd32, 16'd0);
		repeat (40) random_word();
		drain();

		run_phase(16'd0, 16'd32768, 60);
		run_phase(16'd1, 16'd1, 40);
		run_phase(16'd1, 16'd0, 30);
		run_phase(16'd32768, 16'd32768, 80);
		run_phase(16'd100, 16'd37, 80);

		// Long sink hold-off while requests keep coming
		rnd_ring = 16'($urandom_range(1, 32768));
		hold_req = 1'b1;
		run_phase(rnd_ring, 16'($urandom_range(0, rnd_ring)), 80);

		// Closing stretch with both streams running flat out
		idle_on = 1'b0;
		run_phase(16'd4096, 16'd0, 90);

		repeat (60) @(posedge clk);
		$display("%0d request words (get %0d, unget %0d, put %0d, query %0d, reset %0d)",
			words_sent, mode_hits[MODE_GET], mode_hits[MODE_UNGET], mode_hits[MODE_PUT],
			mode_hits[MODE_QUERY], mode_hits[MODE_RESET]);
		$display("over %0d ring settings; %0d result words checked, %0d mismatches",
			settings_used, book.results_seen, book.mismatches);
		if (book.mismatches == 0 && book.awaited.size() == 0) begin
			$display("dual_line_ring_chunk_manager_test passed");
		end else begin
			$display("dual_line_ring_chunk_manager_test failed");
		end
		$finish;
	end

endmodule
